// File: hdl/mcrc_pkg.sv
package mcrc_pkg;

  localparam logic [15:0] CRC_INIT = 16'hFFFF;
  localparam logic [15:0] CRC_POLY = 16'hA001;

  // One queued transaction, already classified by the front end.
  typedef struct packed {
    logic [7:0]  data;
    logic        last;
    logic        valid;    // last byte and remainder is zero
    logic        trailer;  // two CRC bytes follow the echo
    logic [15:0] crc;
  } mcrc_entry_t;

  typedef struct packed {
    logic empty;
    logic full;
  } mcrc_qstat_t;

  // Reflected CRC-16, all eight shifts for one byte.
  function automatic logic [15:0] crc_byte(input logic [15:0] crc, input logic [7:0] b);
    logic [15:0] c;
    c = crc ^ {8'h00, b};
    for (int k = 0; k < 8; k++) begin
      if (c[0]) begin
        c = (c >> 1) ^ CRC_POLY;
      end else begin
        c = c >> 1;
      end
    end
    return c;
  endfunction

endpackage

// File: hdl/mcrc_front.sv
module mcrc_front (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 cfg_we,
  input  logic                 cfg_wdata,
  input  logic                 in_valid,
  output logic                 in_stall,
  input  logic [7:0]           data_byte,
  input  logic                 last_byte,
  input  mcrc_pkg::mcrc_qstat_t q_stat,
  output logic                 q_push,
  output mcrc_pkg::mcrc_entry_t q_wdata
);
  import mcrc_pkg::*;

  logic        append_mode;
  logic [15:0] running_crc;
  logic [15:0] crc_next;

  assign crc_next = crc_byte(running_crc, data_byte);
  assign in_stall = q_stat.full;
  assign q_push   = in_valid && !q_stat.full;

  always_comb begin
    q_wdata.data    = data_byte;
    q_wdata.last    = last_byte;
    q_wdata.valid   = last_byte && (crc_next == 16'h0000);
    q_wdata.trailer = last_byte && append_mode && (crc_next != 16'h0000);
    q_wdata.crc     = crc_next;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      append_mode <= 1'b0;
      running_crc <= CRC_INIT;
    end else begin
      if (cfg_we) begin
        append_mode <= cfg_wdata;
      end
      if (q_push) begin
        running_crc <= last_byte ? CRC_INIT : crc_next;
      end
    end
  end

endmodule

// File: hdl/mcrc_fifo.sv
module mcrc_fifo #(
  parameter int DEPTH = 4
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  push,
  input  mcrc_pkg::mcrc_entry_t wdata,
  input  logic                  pop,
  output mcrc_pkg::mcrc_entry_t rdata,
  output mcrc_pkg::mcrc_qstat_t stat
);
  import mcrc_pkg::*;

  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);

  mcrc_entry_t            slots [DEPTH];
  logic [PTR_W-1:0]       wr_ptr;
  logic [PTR_W-1:0]       rd_ptr;
  logic [CNT_W-1:0]       count;
  logic                   do_push;
  logic                   do_pop;

  assign stat.empty = (count == '0);
  assign stat.full  = (count == CNT_W'(DEPTH));
  assign do_push    = push && !stat.full;
  assign do_pop     = pop && !stat.empty;
  assign rdata      = slots[rd_ptr];

  function automatic logic [PTR_W-1:0] bump(input logic [PTR_W-1:0] p);
    return (p == PTR_W'(DEPTH - 1)) ? '0 : p + 1'b1;
  endfunction

  always_ff @(posedge clk) begin
    if (do_push) begin
      slots[wr_ptr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr <= bump(wr_ptr);
      end
      if (do_pop) begin
        rd_ptr <= bump(rd_ptr);
      end
      if (do_push && !do_pop) begin
        count <= count + 1'b1;
      end else if (do_pop && !do_push) begin
        count <= count - 1'b1;
      end
    end
  end

endmodule

// File: hdl/mcrc_back.sv
module mcrc_back (
  input  logic                  clk,
  input  logic                  rst,
  input  mcrc_pkg::mcrc_entry_t q_rdata,
  input  mcrc_pkg::mcrc_qstat_t q_stat,
  output logic                  q_pop,
  output logic                  out_valid,
  input  logic                  out_stall,
  output logic [7:0]            out_byte,
  output logic                  out_last,
  output logic                  frame_valid,
  output logic [15:0]           crc_result
);
  import mcrc_pkg::*;

  typedef enum logic [1:0] {
    PH_ECHO,
    PH_LOW,
    PH_HIGH
  } phase_t;

  phase_t      phase;
  logic        load;
  logic        take;
  logic [15:0] swapped;

  assign load    = !out_valid || !out_stall;
  assign take    = load && !q_stat.empty;
  assign swapped = {q_rdata.crc[7:0], q_rdata.crc[15:8]};
  assign q_pop   = take && ((phase == PH_HIGH) || (phase == PH_ECHO && !q_rdata.trailer));

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
      phase     <= PH_ECHO;
    end else if (load) begin
      out_valid <= !q_stat.empty;
      if (take) begin
        unique case (phase)
          PH_ECHO: begin
            out_byte    <= q_rdata.data;
            out_last    <= q_rdata.last && !q_rdata.trailer;
            frame_valid <= q_rdata.valid;
            crc_result  <= (q_rdata.last && !q_rdata.trailer) ? swapped : 16'h0000;
            phase       <= q_rdata.trailer ? PH_LOW : PH_ECHO;
          end
          PH_LOW: begin
            out_byte    <= q_rdata.crc[7:0];
            out_last    <= 1'b0;
            frame_valid <= 1'b0;
            crc_result  <= 16'h0000;
            phase       <= PH_HIGH;
          end
          PH_HIGH: begin
            out_byte    <= q_rdata.crc[15:8];
            out_last    <= 1'b1;
            frame_valid <= 1'b0;
            crc_result  <= swapped;
            phase       <= PH_ECHO;
          end
          default: begin
            phase <= PH_ECHO;
          end
        endcase
      end
    end
  end

endmodule

// File: hdl/modbus_crc16_frame_check_append_top.sv
// Channel  Direction  Handshake             Payload
// cfg      in         cfg_we                cfg_wdata (append_mode)
// in       in         in_valid / in_stall   data_byte, last_byte
// out      out        out_valid / out_stall out_byte, out_last, frame_valid, crc_result
//
// One input transaction per cycle while in_stall is low; the CRC update is XOR logic in the front end.
// Each byte yields one output byte, or three when a trailer is appended; the output stage
// emits one byte per cycle while out_stall is low.
// Each input transaction is registered in the queue, and the output register loads from the queue.
// rst is synchronous: running CRC to 0xFFFF, append_mode to 0, queue and output emptied.
// in_stall rises only when the queue is full; out_stall backs up into the queue.
module modbus_crc16_frame_check_append_top #(
  parameter int QUEUE_DEPTH = 4
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_we,
  input  logic        cfg_wdata,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [7:0]  data_byte,
  input  logic        last_byte,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [7:0]  out_byte,
  output logic        out_last,
  output logic        frame_valid,
  output logic [15:0] crc_result
);
  import mcrc_pkg::*;

  mcrc_entry_t q_wdata;
  mcrc_entry_t q_rdata;
  mcrc_qstat_t q_stat;
  logic        q_push;
  logic        q_pop;

  mcrc_front u_front (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .data_byte (data_byte),
    .last_byte (last_byte),
    .q_stat    (q_stat),
    .q_push    (q_push),
    .q_wdata   (q_wdata)
  );

  mcrc_fifo #(
    .DEPTH (QUEUE_DEPTH)
  ) u_fifo (
    .clk   (clk),
    .rst   (rst),
    .push  (q_push),
    .wdata (q_wdata),
    .pop   (q_pop),
    .rdata (q_rdata),
    .stat  (q_stat)
  );

  mcrc_back u_back (
    .clk         (clk),
    .rst         (rst),
    .q_rdata     (q_rdata),
    .q_stat      (q_stat),
    .q_pop       (q_pop),
    .out_valid   (out_valid),
    .out_stall   (out_stall),
    .out_byte    (out_byte),
    .out_last    (out_last),
    .frame_valid (frame_valid),
    .crc_result  (crc_result)
  );

endmodule
